[rtl/onpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpd_pkg: shared types and constants of the null-symbol power-dip detector
// Field widths, the block transfer record, configuration bundle, register
// indexes and the back-end sequencer states.
// ----------------------------------------------------------------------------
package onpd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_BLOCK_LOG2 = 10;

    localparam int KLOG_W  = 4;                                // block_len_log2 register
    localparam int CNT_W   = MAX_BLOCK_LOG2 + 1;               // holds the block length itself
    localparam int MAG_W   = SAMPLE_BITS + 1;                  // |x|, -2^(n-1) included
    localparam int ACC_W   = MAX_BLOCK_LOG2 + SAMPLE_BITS + 1; // block sum of |I|+|Q|
    localparam int LVL_W   = SAMPLE_BITS + 1;                  // block mean, integer
    localparam int FRAC_W  = 16;                               // running level fraction
    localparam int RUN_W   = LVL_W + FRAC_W;                   // running level, Q17.16
    localparam int COEF_W  = 16;                               // beta and thresholds
    localparam int THR_FRAC  = 12;                             // thresholds are Q4.12
    localparam int CMP_SHIFT = FRAC_W + THR_FRAC;
    localparam int LHS_W   = LVL_W + CMP_SHIFT;                // block sum scaled for compare
    localparam int PROD_W  = RUN_W + COEF_W;                   // level times threshold
    localparam int DEC_W   = 8;
    localparam int DIP_W   = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_BLOCK_LEN_LOG2 = 3'd0;
    localparam logic [2:0] REG_AVG_DECIMATE   = 3'd1;
    localparam logic [2:0] REG_AVG_BETA       = 3'd2;
    localparam logic [2:0] REG_THRESH_START   = 3'd3;
    localparam logic [2:0] REG_THRESH_END     = 3'd4;

    localparam logic [KLOG_W-1:0] RST_BLOCK_LEN_LOG2 = 4'd4;
    localparam logic [DEC_W-1:0]  RST_AVG_DECIMATE   = 8'd1;
    localparam logic [COEF_W-1:0] RST_AVG_BETA       = 16'd62259;
    localparam logic [COEF_W-1:0] RST_THRESH_START   = 16'd1434;
    localparam logic [COEF_W-1:0] RST_THRESH_END     = 16'd3072;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
        logic                          search_enable;
        logic                          restart;
    } sample_t;

    typedef struct packed {
        logic [DIP_W-1:0] dip_length;
        logic [LVL_W-1:0] level_average;
        logic [LVL_W-1:0] block_level;
    } result_t;

    // one finished block, front to back
    typedef struct packed {
        logic [ACC_W-1:0]  acc;       // sum of |I|+|Q|
        logic [KLOG_W-1:0] klog;      // block length log2 in force
        logic [CNT_W-1:0]  n_search;  // samples with search enabled
        logic              search;    // search enable of the closing sample
        logic              restart;   // a restart fell inside the block
    } block_evt_t;

    // effective configuration (clamped)
    typedef struct packed {
        logic [KLOG_W-1:0] klog;
        logic [DEC_W-1:0]  dec;
        logic [COEF_W-1:0] beta;
        logic [COEF_W-1:0] t_start;
        logic [COEF_W-1:0] t_end;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD,
        ST_THR,
        ST_CMP
    } back_state_t;

endpackage

[rtl/onpd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpd_fifo: small register queue
// Holds finished blocks between the sample front end and the level back end.
// ----------------------------------------------------------------------------
module onpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/onpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpd_front: sample front end
// Sums |I|+|Q| per block, counts search samples, notes restarts and hands
// each finished block to the queue.
// ----------------------------------------------------------------------------
module onpd_front
    import onpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              q_full,
    input  sample_t           sample,
    input  logic [KLOG_W-1:0] klog,
    output logic              evt_push,
    output block_evt_t        evt
);

    function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
        logic [MAG_W-1:0] ext;
        begin
            ext = {v[SAMPLE_BITS-1], v};
            mag_of = v[SAMPLE_BITS-1] ? (~ext + 1'b1) : ext;
        end
    endfunction

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] srch_reg, srch_next;
    logic             rst_seen_reg, rst_seen_next;

    logic             accept;
    logic [ACC_W-1:0] acc_sum;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] srch_inc;
    logic [CNT_W-1:0] blk_len;
    logic             blk_end;
    logic             rst_any;

    assign accept   = push && !q_full;
    assign acc_sum  = acc_reg + ACC_W'(mag_of(sample.sample_i)) + ACC_W'(mag_of(sample.sample_q));
    assign cnt_inc  = cnt_reg + 1'b1;
    assign srch_inc = srch_reg + CNT_W'(sample.search_enable);
    assign blk_len  = CNT_W'(1) << klog;
    // also closes a block at once when the length was lowered mid-block
    assign blk_end  = (cnt_inc >= blk_len);
    assign rst_any  = rst_seen_reg || sample.restart;

    assign evt_push     = accept && blk_end;
    assign evt.acc      = acc_sum;
    assign evt.klog     = klog;
    assign evt.n_search = srch_inc;
    assign evt.search   = sample.search_enable;
    assign evt.restart  = rst_any;

    always_comb
    begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        srch_next     = srch_reg;
        rst_seen_next = rst_seen_reg;
        if (accept)
        begin
            if (blk_end)
            begin
                acc_next      = '0;
                cnt_next      = '0;
                srch_next     = '0;
                rst_seen_next = 1'b0;
            end
            else
            begin
                acc_next      = acc_sum;
                cnt_next      = cnt_inc;
                srch_next     = srch_inc;
                rst_seen_next = rst_any;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            cnt_reg      <= '0;
            srch_reg     <= '0;
            rst_seen_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            srch_reg     <= srch_next;
            rst_seen_reg <= rst_seen_next;
        end
    end

endmodule

[rtl/onpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpd_back: level back end
// Per block: dip counter, running level update, threshold compares and the
// result register.
// ----------------------------------------------------------------------------
module onpd_back
    import onpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  block_evt_t q_head,
    output logic       q_pop,
    input  cfg_t       cfg,
    input  logic       pop,
    output logic       empty,
    output result_t    result
);

    localparam int SH_W  = ACC_W + FRAC_W;
    localparam int LSH_W = ACC_W + CMP_SHIFT;
    localparam int HI_W  = RUN_W - FRAC_W;
    localparam int MB_W  = COEF_W + 1;

    back_state_t state_reg, state_next;

    logic [RUN_W-1:0]  run_reg, run_next;
    logic              armed_reg, armed_next;
    logic [DIP_W-1:0]  dcnt_reg, dcnt_next;
    logic [DEC_W-1:0]  dec_reg, dec_next;
    logic [KLOG_W-1:0] klog_reg;
    logic              search_reg;
    logic [RUN_W-1:0]  x_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [LHS_W-1:0]  lhs_reg;

    logic [2*COEF_W-1:0]      pk_lo_reg, ps_lo_reg, pe_lo_reg;
    logic [COEF_W+HI_W-1:0]   pk_hi_reg, ps_hi_reg, pe_hi_reg;
    logic [MB_W+FRAC_W-1:0]   pt_lo_reg;
    logic [MB_W+HI_W-1:0]     pt_hi_reg;
    logic [PROD_W-1:0]        keep_reg;
    logic [PROD_W:0]          take_reg;

    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    // sequencer strobes
    logic do_mul, do_sum, do_upd, do_thr, do_cmp;

    logic [SH_W-1:0]   x_wide;
    logic [ACC_W-1:0]  lvl_wide;
    logic [LSH_W-1:0]  lhs_wide;
    logic [DIP_W:0]    dcnt_sum;
    logic [DIP_W-1:0]  dcnt_sat;
    logic [MB_W-1:0]   mb;
    logic [PROD_W+1:0] run_sum;
    logic [DEC_W:0]    dec_inc;
    logic [PROD_W-1:0] prod_s, prod_e;
    logic              end_hit, arm_hit, out_room, cmp_go;

    // ---------------------------------------------------------------- compare
    assign prod_s   = {ps_hi_reg, {FRAC_W{1'b0}}} + PROD_W'(ps_lo_reg);
    assign prod_e   = {pe_hi_reg, {FRAC_W{1'b0}}} + PROD_W'(pe_lo_reg);
    assign end_hit  = search_reg && armed_reg && (PROD_W'(lhs_reg) > prod_e);
    assign arm_hit  = search_reg && !armed_reg && (PROD_W'(lhs_reg) < prod_s);
    assign out_room = !out_valid_reg || pop;
    assign cmp_go   = !end_hit || out_room;

    // ------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_THR;
            ST_THR:  state_next = ST_CMP;
            ST_CMP:  if (cmp_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- strobes
    always_comb
    begin
        q_pop  = 1'b0;
        do_mul = 1'b0;
        do_sum = 1'b0;
        do_upd = 1'b0;
        do_thr = 1'b0;
        do_cmp = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop  = !q_empty;
            ST_MUL:  do_mul = 1'b1;
            ST_SUM:  do_sum = 1'b1;
            ST_UPD:  do_upd = 1'b1;
            ST_THR:  do_thr = 1'b1;
            ST_CMP:  do_cmp = cmp_go;
            default: q_pop  = 1'b0;
        endcase
    end

    // --------------------------------------------------------------- datapath
    assign x_wide   = {q_head.acc, {FRAC_W{1'b0}}} >> q_head.klog;
    assign lvl_wide = q_head.acc >> q_head.klog;
    assign lhs_wide = {q_head.acc, {CMP_SHIFT{1'b0}}} >> q_head.klog;
    assign dcnt_sum = {1'b0, dcnt_reg} + (DIP_W+1)'(q_head.n_search);
    assign dcnt_sat = dcnt_sum[DIP_W] ? {DIP_W{1'b1}} : dcnt_sum[DIP_W-1:0];
    assign mb       = {1'b1, {COEF_W{1'b0}}} - MB_W'(cfg.beta);
    assign run_sum  = (PROD_W+2)'(keep_reg) + (PROD_W+2)'(take_reg);
    assign dec_inc  = {1'b0, dec_reg} + 1'b1;

    always_comb
    begin
        run_next       = run_reg;
        armed_next     = armed_reg;
        dcnt_next      = dcnt_reg;
        dec_next       = dec_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (q_pop)
        begin
            if (q_head.restart)
            begin
                run_next   = '0;
                armed_next = 1'b0;
                dcnt_next  = '0;
            end
            else if (armed_reg)
            begin
                dcnt_next = dcnt_sat;
            end
        end

        if (do_upd)
        begin
            if (dec_reg == '0)
            begin
                run_next = run_sum[FRAC_W +: RUN_W];
            end
            dec_next = (dec_inc >= {1'b0, cfg.dec}) ? '0 : dec_inc[DEC_W-1:0];
        end

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        if (do_cmp)
        begin
            if (end_hit)
            begin
                out_valid_next         = 1'b1;
                out_next.dip_length    = dcnt_reg;
                out_next.level_average = run_reg[RUN_W-1:FRAC_W];
                out_next.block_level   = lvl_reg;
                armed_next             = 1'b0;
                dcnt_next              = '0;
            end
            else if (arm_hit)
            begin
                armed_next = 1'b1;
                dcnt_next  = DIP_W'(CNT_W'(1) << klog_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= '0;
            armed_reg     <= 1'b0;
            dcnt_reg      <= '0;
            dec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            armed_reg     <= armed_next;
            dcnt_reg      <= dcnt_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (q_pop)
        begin
            klog_reg   <= q_head.klog;
            search_reg <= q_head.search;
            x_reg      <= x_wide[RUN_W-1:0];
            lvl_reg    <= lvl_wide[LVL_W-1:0];
            lhs_reg    <= lhs_wide[LHS_W-1:0];
        end
        if (do_mul)
        begin
            pk_lo_reg <= cfg.beta * run_reg[FRAC_W-1:0];
            pk_hi_reg <= cfg.beta * run_reg[RUN_W-1:FRAC_W];
            pt_lo_reg <= mb * x_reg[FRAC_W-1:0];
            pt_hi_reg <= mb * x_reg[RUN_W-1:FRAC_W];
        end
        if (do_sum)
        begin
            keep_reg <= {pk_hi_reg, {FRAC_W{1'b0}}} + PROD_W'(pk_lo_reg);
            take_reg <= {pt_hi_reg, {FRAC_W{1'b0}}} + (PROD_W+1)'(pt_lo_reg);
        end
        if (do_thr)
        begin
            ps_lo_reg <= cfg.t_start * run_reg[FRAC_W-1:0];
            ps_hi_reg <= cfg.t_start * run_reg[RUN_W-1:FRAC_W];
            pe_lo_reg <= cfg.t_end * run_reg[FRAC_W-1:0];
            pe_hi_reg <= cfg.t_end * run_reg[RUN_W-1:FRAC_W];
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

[rtl/ofdm_null_symbol_power_dip_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdm_null_symbol_power_dip_detector: OFDM null-symbol detector
// Block L1 level, exponential running level and dip start/end detection.
// ----------------------------------------------------------------------------
// Takes one complex sample per clock while full is low and reports each power
// dip (null symbol) as one result transfer: dip length in samples, the running
// level and the level of the block that ended the dip. The front end sums
// |I|+|Q| and accepts a sample every cycle while the queue has room; each
// finished block goes into a four-entry queue, and the back end takes one block
// at a time through its steps (load, level multiply, partial sum, level update,
// threshold multiply, compare); the compare waits while a dip end finds the
// output register full. The multiplier sequence on the running level feeds
// back from block to block. Blocks of 8 samples or more (block_len_log2 >= 3)
// sustain one sample per cycle while results are taken; shorter blocks are
// limited by the back end once the queue has filled. A result follows the last
// sample of the block that ends the dip and waits in an output register;
// samples keep flowing while it waits. push is refused (full high) only when
// the block queue is full. Registers are on a 32-bit APB-style port at byte
// addresses 0x00..0x10 and should only be written with the block idle.
// ----------------------------------------------------------------------------
module ofdm_null_symbol_power_dip_detector
    import onpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // sample side
    input  logic              push,
    output logic              full,
    input  sample_t           sample,
    // result side
    output logic              empty,
    input  logic              pop,
    output result_t           result,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------ registers
    logic [KLOG_W-1:0] blk_log2_reg, blk_log2_next;
    logic [DEC_W-1:0]  decimate_reg, decimate_next;
    logic [COEF_W-1:0] beta_reg, beta_next;
    logic [COEF_W-1:0] t_start_reg, t_start_next;
    logic [COEF_W-1:0] t_end_reg, t_end_next;

    logic       wr_en;
    logic [2:0] reg_idx;
    cfg_t       cfg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        blk_log2_next = blk_log2_reg;
        decimate_next = decimate_reg;
        beta_next     = beta_reg;
        t_start_next  = t_start_reg;
        t_end_next    = t_end_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_BLOCK_LEN_LOG2: blk_log2_next = pwdata[KLOG_W-1:0];
                REG_AVG_DECIMATE:   decimate_next = pwdata[DEC_W-1:0];
                REG_AVG_BETA:       beta_next     = pwdata[COEF_W-1:0];
                REG_THRESH_START:   t_start_next  = pwdata[COEF_W-1:0];
                REG_THRESH_END:     t_end_next    = pwdata[COEF_W-1:0];
                default:            blk_log2_next = blk_log2_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BLOCK_LEN_LOG2: prdata = DATA_W'(blk_log2_reg);
            REG_AVG_DECIMATE:   prdata = DATA_W'(decimate_reg);
            REG_AVG_BETA:       prdata = DATA_W'(beta_reg);
            REG_THRESH_START:   prdata = DATA_W'(t_start_reg);
            REG_THRESH_END:     prdata = DATA_W'(t_end_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_log2_reg <= RST_BLOCK_LEN_LOG2;
            decimate_reg <= RST_AVG_DECIMATE;
            beta_reg     <= RST_AVG_BETA;
            t_start_reg  <= RST_THRESH_START;
            t_end_reg    <= RST_THRESH_END;
        end
        else
        begin
            blk_log2_reg <= blk_log2_next;
            decimate_reg <= decimate_next;
            beta_reg     <= beta_next;
            t_start_reg  <= t_start_next;
            t_end_reg    <= t_end_next;
        end
    end

    // oversized block length acts as the maximum; zero decimation acts as one
    assign cfg.klog    = (blk_log2_reg > KLOG_W'(MAX_BLOCK_LOG2)) ?
                         KLOG_W'(MAX_BLOCK_LOG2) : blk_log2_reg;
    assign cfg.dec     = (decimate_reg == '0) ? DEC_W'(1) : decimate_reg;
    assign cfg.beta    = beta_reg;
    assign cfg.t_start = t_start_reg;
    assign cfg.t_end   = t_end_reg;

    // ------------------------------------------------------------ datapath
    logic       evt_push;
    block_evt_t evt_in;
    block_evt_t evt_head;
    logic       q_full, q_empty, q_pop;

    assign full = q_full;

    onpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_full   (q_full),
        .sample   (sample),
        .klog     (cfg.klog),
        .evt_push (evt_push),
        .evt      (evt_in)
    );

    // finished blocks waiting for the back end
    onpd_fifo #(
        .WIDTH ($bits(block_evt_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evt_push),
        .wr_data (evt_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (evt_head),
        .empty   (q_empty)
    );

    onpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (evt_head),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

[rtl/onpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpd_checker: port-level checks for the dip detector
// Watches the sample side, the result side and the register port; bound to
// the top level.
// ----------------------------------------------------------------------------
module onpd_checker
    import onpd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input sample_t           sample,
    input logic              empty,
    input logic              pop,
    input result_t           result,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    localparam logic [ADDR_W-1:0] BETA_ADDR = ADDR_W'({REG_AVG_BETA, 2'b00});

    // nothing waits on either side while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queue not idle during reset");

    // a refused sample is held unchanged until taken
    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |=> (push && $stable(sample)))
        else $error("refused sample dropped or changed");

    // a waiting result is neither dropped nor changed until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result lost or changed");

    // a dip always covers at least the arming block
    a_dip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.dip_length != '0))
        else $error("zero dip length reported");

    // a written keep factor reads back
    a_beta_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr == BETA_ADDR))
        ##1 (psel && !pwrite && (paddr == BETA_ADDR))
        |-> (prdata[COEF_W-1:0] == $past(pwdata[COEF_W-1:0])))
        else $error("keep factor read back wrong");

endmodule

bind ofdm_null_symbol_power_dip_detector onpd_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .sample  (sample),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);

[dv/ofdm_null_symbol_power_dip_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdm_null_symbol_power_dip_detector_tb: self-checking bench for the detector
// Streams complex samples through the detector and checks every dip report
// against a cycle-free predictor of block levels, running level and dip state.
// ----------------------------------------------------------------------------
// A driver and a monitor run as clocked always blocks. The driver takes samples
// from a backlog that the stimulus process fills and runs the predictor on each
// accepted transfer; the monitor pops results and checks them in order against
// the predicted dips. Registers are only written with the detector drained:
// backlog empty, every predicted dip received and a settling pause after.
// ----------------------------------------------------------------------------
module ofdm_null_symbol_power_dip_detector_tb
    import onpd_pkg::*;
();

    localparam int SETTLE_CYCLES  = 64;      // drains the block queue, the back end and the result register
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_SAMPLES = 700;
    localparam int PHASE_SAMPLES  = 150;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b1;
    logic              push    = 1'b0;
    logic              full;
    sample_t           sample  = '0;
    logic              empty;
    logic              pop     = 1'b0;
    result_t           result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ofdm_null_symbol_power_dip_detector u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: shadow registers and the detector's own state
    // ------------------------------------------------------------------------
    logic [KLOG_W-1:0] cfg_klog    = RST_BLOCK_LEN_LOG2;
    logic [DEC_W-1:0]  cfg_dec     = RST_AVG_DECIMATE;
    logic [COEF_W-1:0] cfg_beta    = RST_AVG_BETA;
    logic [COEF_W-1:0] cfg_t_start = RST_THRESH_START;
    logic [COEF_W-1:0] cfg_t_end   = RST_THRESH_END;

    logic [63:0]       blk_sum     = '0;   // sum of |I|+|Q| in the open block
    int unsigned       blk_fill    = 0;    // samples in the open block
    int unsigned       dec_pos     = 0;    // block position within decimation period
    logic [63:0]       run_level   = '0;   // running level, Q17.16
    bit                armed       = 1'b0;
    logic [DIP_W-1:0]  dip_count   = '0;

    sample_t           sample_backlog[$];
    result_t           expected_dips[$];
    result_t           dip_want;

    int                send_idle_pct = 32;
    int                take_idle_pct = 32;
    int                mismatch_count = 0;
    int                cycle_count = 0;

    function automatic logic [MAG_W-1:0] abs_component(input logic [SAMPLE_BITS-1:0] raw);
        if (raw[SAMPLE_BITS-1])
            return (MAG_W'(1) << SAMPLE_BITS) - MAG_W'(raw);
        return MAG_W'(raw);
    endfunction

    function automatic void backlog_add(input sample_t s);
        sample_backlog = {sample_backlog, s};
    endfunction

    // Advance the detector by one sample and queue the dip report it causes.
    // The running level moves before the threshold tests of the same block.
    task automatic track_power_dip(input sample_t s);
        logic [KLOG_W-1:0] k;
        int unsigned       dec;
        logic [63:0]       acc;
        logic [63:0]       lvl;
        logic [63:0]       lhs;
        logic [63:0]       keep;
        logic [63:0]       take;
        result_t           dip;
        k   = (cfg_klog > KLOG_W'(MAX_BLOCK_LOG2)) ? KLOG_W'(MAX_BLOCK_LOG2) : cfg_klog;
        dec = (cfg_dec == 0) ? 1 : cfg_dec;
        if (s.restart)
        begin
            run_level = '0;
            armed     = 1'b0;
            dip_count = '0;
        end
        blk_sum = blk_sum + abs_component(s.sample_i) + abs_component(s.sample_q);
        if (s.search_enable && armed && dip_count != {DIP_W{1'b1}})
            dip_count = dip_count + 1'b1;
        blk_fill++;
        // a lowered block length closes an over-full block on the next sample
        if (blk_fill < (32'd1 << k))
            return;

        acc      = blk_sum;
        lvl      = acc >> k;
        blk_sum  = '0;
        blk_fill = 0;

        if (dec_pos == 0)
        begin
            keep      = 64'(cfg_beta) * run_level;
            take      = (64'd65536 - 64'(cfg_beta)) * ((acc << FRAC_W) >> k);
            run_level = (keep + take) >> FRAC_W;
        end
        dec_pos++;
        if (dec_pos >= dec)
            dec_pos = 0;

        if (!s.search_enable)
            return;

        // exact mean against level x factor, both scaled by 2^28
        lhs = acc << (CMP_SHIFT - k);
        if (armed)
        begin
            if (lhs > run_level * 64'(cfg_t_end))
            begin
                dip.dip_length    = dip_count;
                dip.level_average = run_level[FRAC_W +: LVL_W];
                dip.block_level   = lvl[LVL_W-1:0];
                expected_dips     = {expected_dips, dip};
                armed     = 1'b0;
                dip_count = '0;
            end
        end
        else if (lhs < run_level * 64'(cfg_t_start))
        begin
            armed     = 1'b1;
            dip_count = DIP_W'(32'd1 << k);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample driver: one transfer per accepting edge, random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                track_power_dip(sample);
            if (!push || !full)
            begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample <= sample_backlog.pop_front();
                    push   <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: random pop, in-order compare against predicted dips
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_dips.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] dip report with none predicted: len=%0d avg=%0d blk=%0d",
                                 $realtime, result.dip_length, result.level_average,
                                 result.block_level);
                end
                else
                begin
                    dip_want = expected_dips.pop_front();
                    if (result.dip_length !== dip_want.dip_length
                        || result.level_average !== dip_want.level_average
                        || result.block_level !== dip_want.block_level)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"[%0t] dip mismatch: expected len=%0d avg=%0d blk=%0d,",
                                      " got len=%0d avg=%0d blk=%0d"},
                                     $realtime, dip_want.dip_length, dip_want.level_average,
                                     dip_want.block_level, result.dip_length,
                                     result.level_average, result.block_level);
                    end
                end
            end
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ofdm_null_symbol_power_dip_detector_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // setup cycle, access cycle, register takes the value at the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BLOCK_LEN_LOG2: cfg_klog    = value[KLOG_W-1:0];
            REG_AVG_DECIMATE:   cfg_dec     = value[DEC_W-1:0];
            REG_AVG_BETA:       cfg_beta    = value[COEF_W-1:0];
            REG_THRESH_START:   cfg_t_start = value[COEF_W-1:0];
            REG_THRESH_END:     cfg_t_end   = value[COEF_W-1:0];
            default: ;
        endcase
    endtask

    // backlog drained, every predicted dip received, then the pipeline settles
    task automatic wait_idle();
        while (sample_backlog.size() != 0 || push)
            @(negedge clk);
        while (expected_dips.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic sample_t pack_sample(input int i, input int q, input bit search,
                                            input bit clear);
        sample_t s;
        s.sample_i      = i[SAMPLE_BITS-1:0];
        s.sample_q      = q[SAMPLE_BITS-1:0];
        s.search_enable = search;
        s.restart       = clear;
        return s;
    endfunction

    function automatic int rand_component(input int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic sample_t make_sample(input int amp, input bit search, input bit clear);
        return pack_sample(rand_component(amp), rand_component(amp), search, clear);
    endfunction

    // One frame: loud carrier, then a null stretch, both off the block grid.
    // One frame in five is plain noise with random search and restart bits.
    function automatic int queue_frame(input int blen);
        int loud_n;
        int quiet_n;
        int a_loud;
        int a_quiet;
        bit search;
        if ($urandom_range(99) < 20)
        begin
            loud_n = $urandom_range(1, 2 * blen + 8);
            repeat (loud_n)
                backlog_add(pack_sample(int'($urandom_range(0, 65535)) - 32768,
                                        int'($urandom_range(0, 65535)) - 32768,
                                        $urandom_range(0, 1),
                                        $urandom_range(0, 19) == 0));
            return loud_n;
        end
        search  = ($urandom_range(0, 19) != 0);
        loud_n  = $urandom_range(2, blen <= 8 ? 8 : 3) * blen + $urandom_range(0, blen - 1);
        quiet_n = $urandom_range(1, 3) * blen + $urandom_range(0, blen - 1);
        a_loud  = $urandom_range(4000, 32767);
        a_quiet = $urandom_range(0, a_loud / 20);
        repeat (loud_n)
            backlog_add(make_sample(a_loud, search, $urandom_range(0, 199) == 0));
        repeat (quiet_n)
            backlog_add(make_sample(a_quiet, search, 1'b0));
        return loud_n + quiet_n;
    endfunction

    task automatic write_random_config();
        int r;
        r = $urandom_range(0, 9);
        write_reg(REG_BLOCK_LEN_LOG2, (r < 6) ? $urandom_range(0, 3) :
                                      (r < 9) ? $urandom_range(4, 5) : 6);
        r = $urandom_range(0, 19);
        write_reg(REG_AVG_DECIMATE, (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 4));
        r = $urandom_range(0, 19);
        write_reg(REG_AVG_BETA, (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(16384, 62259));
        r = $urandom_range(0, 19);
        write_reg(REG_THRESH_START, (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(600, 3000));
        r = $urandom_range(0, 19);
        write_reg(REG_THRESH_END, (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(2048, 6000));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int blen;
        int pad;
        int phase_samples;
        int random_total;

        rst_n <= 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed, one sample per block. No smoothing and a huge start factor,
        // so any non-zero block arms; a zero block then drops the running level
        // to zero while armed and the next non-zero block ends the dip.
        write_reg(REG_BLOCK_LEN_LOG2, 0);
        write_reg(REG_AVG_DECIMATE, 1);
        write_reg(REG_AVG_BETA, 0);
        write_reg(REG_THRESH_START, 65535);
        write_reg(REG_THRESH_END, RST_THRESH_END);
        @(negedge clk);
        backlog_add(pack_sample(32767, -32768, 1, 1));
        backlog_add(pack_sample(0, 0, 1, 0));
        backlog_add(pack_sample(-32768, -32768, 1, 0));   // full-scale report
        backlog_add(pack_sample(1, -1, 0, 0));            // level tracking only
        backlog_add(pack_sample(-1, 0, 0, 1));            // restart, search off
        backlog_add(pack_sample(100, 200, 1, 0));
        backlog_add(pack_sample(5, 5, 0, 0));             // count holds
        backlog_add(pack_sample(7, -7, 0, 0));
        backlog_add(pack_sample(0, 0, 1, 0));
        backlog_add(pack_sample(0, 1, 1, 0));
        backlog_add(pack_sample(-32768, 32767, 1, 0));
        backlog_add(pack_sample(32767, 32767, 1, 1));     // restart while armed
        wait_idle();

        // Block length cut while a block is part-filled: it closes at once.
        write_reg(REG_BLOCK_LEN_LOG2, 3);
        @(negedge clk);
        repeat (5)
            backlog_add(make_sample(20000, 1'b1, 1'b0));
        wait_idle();
        write_reg(REG_BLOCK_LEN_LOG2, 1);
        @(negedge clk);
        backlog_add(pack_sample(0, 0, 1, 0));
        backlog_add(pack_sample(30000, 1, 1, 0));
        backlog_add(pack_sample(0, 0, 1, 0));
        backlog_add(pack_sample(-5, 3, 1, 0));
        wait_idle();

        // Oversized block length and zero decimation, run without gaps on
        // either side. The open block is filled up to the maximum length and
        // arms; one-sample blocks then end the dip one sample later.
        write_reg(REG_BLOCK_LEN_LOG2, 15);
        write_reg(REG_AVG_DECIMATE, 0);
        write_reg(REG_AVG_BETA, 0);
        write_reg(REG_THRESH_START, 65535);
        write_reg(REG_THRESH_END, 0);
        @(negedge clk);
        send_idle_pct = 0;
        take_idle_pct = 0;
        pad = (1 << MAX_BLOCK_LOG2) - blk_fill;
        for (int n = 0; n < pad; n++)
            backlog_add(make_sample(20000, 1'b1, n == 0));
        wait_idle();
        write_reg(REG_BLOCK_LEN_LOG2, 0);
        @(negedge clk);
        backlog_add(pack_sample(100, 200, 1, 0));
        wait_idle();
        send_idle_pct = 32;
        take_idle_pct = 32;

        // Random phases: new settings each time, frames of carrier and null.
        random_total = 0;
        while (random_total < RANDOM_SAMPLES)
        begin
            write_random_config();
            @(negedge clk);
            blen = 1 << ((cfg_klog > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : cfg_klog);
            phase_samples = 0;
            while (phase_samples < PHASE_SAMPLES)
                phase_samples += queue_frame(blen);
            random_total += phase_samples;
            wait_idle();
        end

        mismatch_count += expected_dips.size();
        if (mismatch_count == 0)
            $display("ofdm_null_symbol_power_dip_detector_tb passed");
        else
            $display("ofdm_null_symbol_power_dip_detector_tb failed");
        $finish;
    end

endmodule
